// File: src/text_to_morse_element_encoder_core_assert.svh
// Assertion macros for the Morse element encoder.
// Included by modules that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef TEXT_TO_MORSE_ELEMENT_ENCODER_CORE_ASSERT_SVH
`define TEXT_TO_MORSE_ELEMENT_ENCODER_CORE_ASSERT_SVH

// generic clocked assertion with explicit clock and active-low reset
`define TMENC_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// default clock and reset of the block
`define TMENC_ASSERT(lbl, prop, msg) \
  `TMENC_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// File: src/tmenc_pkg.sv
// Package for the Morse element encoder: codes, gap constants, command/status
// structs and the character-to-Morse lookup. No dependencies.
`default_nettype none

package tmenc_pkg;

  localparam int unsigned RomSize = 102;

  localparam logic [1:0] ELEM_DIT = 2'd0;
  localparam logic [1:0] ELEM_DAH = 2'd1;
  localparam logic [1:0] ELEM_SIL = 2'd2;

  localparam logic [4:0] UNITS_PARA   = 5'd14;
  localparam logic [4:0] UNITS_SECT   = 5'd28;
  localparam logic [4:0] UNITS_WORD   = 5'd4;
  localparam logic [4:0] UNITS_LETTER = 5'd3;
  localparam logic [4:0] UNITS_ELEM   = 5'd1;

  localparam logic [5:0] STRETCH_PARA   = 6'd21;
  localparam logic [5:0] STRETCH_SECT   = 6'd42;
  localparam logic [5:0] STRETCH_WORD   = 6'd4;
  localparam logic [5:0] STRETCH_LETTER = 6'd3;

  localparam logic [20:0] CHAR_CR = 21'd13;
  localparam logic [20:0] CHAR_LF = 21'd10;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_BREAK,
    EMIT_WORD,
    EMIT_LETTER,
    EMIT_MARK,
    EMIT_GAP
  } emit_e;

  typedef struct packed {
    logic  load;
    emit_e emit;
    logic  last;
  } tmenc_cmd_t;

  typedef struct packed {
    logic printable;
    logic brk_pend;
    logic word_pend;
    logic out_free;
    logic no_marks;
    logic mark_last;
  } tmenc_status_t;

  // (length << 8) | pattern, pattern MSB first
  localparam logic [10:0] MORSE_ROM [RomSize] = '{
    11'h000, 11'h000, 11'h000, 11'h000, 11'h000, 11'h000, 11'h000, 11'h000,
    11'h000, 11'h000, 11'h000, 11'h000, 11'h000, 11'h000, 11'h000, 11'h000,
    11'h000, 11'h000, 11'h000, 11'h000, 11'h000, 11'h000, 11'h000, 11'h000,
    11'h000, 11'h000, 11'h000, 11'h000, 11'h000, 11'h000, 11'h000, 11'h000,
    11'h000,
    11'h62B, 11'h612, 11'h000, 11'h709, 11'h605, 11'h000, 11'h61E,
    11'h516, 11'h62D, 11'h515, 11'h50A, 11'h633, 11'h621, 11'h615, 11'h512,
    11'h51F, 11'h50F, 11'h507, 11'h503, 11'h501, 11'h500, 11'h510, 11'h518,
    11'h51C, 11'h51E,
    11'h638, 11'h62A, 11'h000, 11'h511, 11'h000, 11'h60C, 11'h61A,
    11'h201, 11'h408, 11'h40A, 11'h304, 11'h100, 11'h402, 11'h306, 11'h400,
    11'h200, 11'h407, 11'h305, 11'h404, 11'h203, 11'h202, 11'h307, 11'h406,
    11'h40D, 11'h302, 11'h300, 11'h101, 11'h301, 11'h401, 11'h303, 11'h409,
    11'h40B, 11'h40C,
    11'h000, 11'h000, 11'h000, 11'h000, 11'h60D,
    11'h405, 11'h40E, 11'h50D, 11'h514, 11'h403, 11'h504
  };

  function automatic logic is_other_space(logic [20:0] c);
    logic sp;
    sp = 1'b0;
    case (c) inside
      21'd9, 21'd11, 21'd12, 21'd32, 21'h1680, 21'h2028, 21'h2029, 21'h205F,
      21'h3000: sp = 1'b1;
      [21'h2000:21'h2006], [21'h2008:21'h200A]: sp = 1'b1;
      default: sp = 1'b0;
    endcase
    return sp;
  endfunction

  // returns {length[2:0], pattern[6:0]}; length zero means no code
  function automatic logic [9:0] morse_lookup(logic [20:0] c);
    logic [20:0] u;
    logic [6:0]  idx;
    logic        hit;
    logic [10:0] entry;
    u = c;
    if (c >= 21'h61 && c <= 21'h7A) begin
      u = c - 21'h20;
    end else if (c >= 21'hE0 && c <= 21'hFE && c != 21'hF7) begin
      u = c - 21'h20;
    end else if (c == 21'h131) begin
      u = 21'h49;
    end else if (c == 21'h17F) begin
      u = 21'h53;
    end
    hit = 1'b1;
    idx = 7'd0;
    if (u <= 21'd95) begin
      idx = u[6:0];
    end else begin
      case (u) inside
        21'hA0:                  idx = 7'd32;
        21'hAB, 21'hBB:          idx = 7'd34;
        21'hC6, 21'hC4:          idx = 7'd96;
        21'hD8, 21'hD6, 21'hD3:  idx = 7'd97;
        21'hC5, 21'hC0:          idx = 7'd98;
        21'hC7:                  idx = 7'd99;
        21'hDC:                  idx = 7'd100;
        21'hC9:                  idx = 7'd101;
        21'hC1:                  idx = 7'd65;
        21'hCF:                  idx = 7'd73;
        21'hCB:                  idx = 7'd69;
        21'h2019:                idx = 7'd39;
        default:                 hit = 1'b0;
      endcase
    end
    entry = hit ? MORSE_ROM[idx] : 11'h000;
    return {entry[10:8], entry[6:0]};
  endfunction

endpackage

`default_nettype wire

// File: src/tmenc_ctrl.sv
// Controller for the Morse element encoder: sequences gaps and marks.
// Depends on tmenc_pkg; drives tmenc_dp through command/status structs.
`default_nettype none

module tmenc_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  tmenc_pkg::tmenc_status_t st_i,
  output tmenc_pkg::tmenc_cmd_t    cmd_o
);
  import tmenc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BRK,
    S_WORD,
    S_LETTER,
    S_MARK,
    S_GAP
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '{load: 1'b0, emit: EMIT_NONE, last: 1'b0};
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (st_i.printable) begin
            if (st_i.brk_pend) begin
              state_d = S_BRK;
            end else if (st_i.word_pend) begin
              state_d = S_WORD;
            end else begin
              state_d = S_LETTER;
            end
          end
        end
      end
      S_BRK: begin
        if (st_i.out_free) begin
          cmd_o.emit = EMIT_BREAK;
          state_d    = S_LETTER;
        end
      end
      S_WORD: begin
        if (st_i.out_free) begin
          cmd_o.emit = EMIT_WORD;
          state_d    = S_LETTER;
        end
      end
      S_LETTER: begin
        if (st_i.out_free) begin
          cmd_o.emit = EMIT_LETTER;
          cmd_o.last = st_i.no_marks;
          state_d    = st_i.no_marks ? S_IDLE : S_MARK;
        end
      end
      S_MARK: begin
        if (st_i.out_free) begin
          cmd_o.emit = EMIT_MARK;
          cmd_o.last = st_i.mark_last;
          state_d    = st_i.mark_last ? S_IDLE : S_GAP;
        end
      end
      S_GAP: begin
        if (st_i.out_free) begin
          cmd_o.emit = EMIT_GAP;
          state_d    = S_MARK;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: src/tmenc_dp.sv
// Datapath for the Morse element encoder: spacing state, lookup, mark shifter
// and output register. Depends on tmenc_pkg and the assertion macro header.
`default_nettype none

module tmenc_dp (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_data_i,
  input  logic [20:0]             char_code_i,
  input  tmenc_pkg::tmenc_cmd_t    cmd_i,
  output tmenc_pkg::tmenc_status_t st_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [1:0]              element_o,
  output logic [4:0]              unit_gaps_o,
  output logic [5:0]              stretch_gaps_o,
  output logic                    unknown_char_o,
  output logic                    last_o
);
  import tmenc_pkg::*;

  logic       fe_q;
  logic [1:0] nl_q, nl_d;
  logic       sp_q, sp_d;
  logic       sect_q;
  logic       unk_q;
  logic [2:0] rem_q;
  logic [6:0] sh_q;

  logic       out_valid_q;
  logic [1:0] element_q;
  logic [4:0] unit_q;
  logic [5:0] stretch_q;
  logic       unknown_q;
  logic       last_q;

  logic       is_cr, is_lf, is_sp, printable;
  logic [9:0] lut;
  logic [2:0] lut_len;
  logic [2:0] lut_sa;

  assign is_cr     = (char_code_i == CHAR_CR);
  assign is_lf     = (char_code_i == CHAR_LF);
  assign is_sp     = is_other_space(char_code_i);
  assign printable = !(is_cr || is_lf || is_sp);
  assign lut       = morse_lookup(char_code_i);
  assign lut_len   = lut[9:7];
  assign lut_sa    = 3'(3'd7 - lut_len);

  assign st_o.printable = printable;
  assign st_o.brk_pend  = nl_q[1];
  assign st_o.word_pend = sp_q;
  assign st_o.out_free  = !out_valid_q || !out_stall_i;
  assign st_o.no_marks  = (rem_q == 3'd0);
  assign st_o.mark_last = (rem_q == 3'd1);

  always_comb begin
    nl_d = nl_q;
    sp_d = sp_q;
    if (cmd_i.load) begin
      if (is_lf) begin
        nl_d = (nl_q == 2'd3) ? nl_q : 2'(nl_q + 2'd1);
        sp_d = 1'b1;
      end else if (is_sp) begin
        sp_d = 1'b1;
      end else if (!is_cr) begin
        nl_d = 2'd0;
        sp_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fe_q        <= 1'b0;
      nl_q        <= 2'd0;
      sp_q        <= 1'b0;
      rem_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        fe_q <= cfg_data_i;
      end
      nl_q <= nl_d;
      sp_q <= sp_d;
      if (cmd_i.load && printable) begin
        rem_q <= lut_len;
      end else if (cmd_i.emit == EMIT_MARK) begin
        rem_q <= 3'(rem_q - 3'd1);
      end
      if (cmd_i.emit != EMIT_NONE) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && printable) begin
      sect_q <= (nl_q == 2'd3);
      unk_q  <= (lut_len == 3'd0);
      sh_q   <= lut[6:0] << lut_sa;
    end else if (cmd_i.emit == EMIT_MARK) begin
      sh_q <= {sh_q[5:0], 1'b0};
    end
    if (cmd_i.emit != EMIT_NONE) begin
      unknown_q <= unk_q;
      last_q    <= cmd_i.last;
      case (cmd_i.emit)
        EMIT_BREAK: begin
          element_q <= ELEM_SIL;
          unit_q    <= sect_q ? UNITS_SECT : UNITS_PARA;
          stretch_q <= fe_q ? (sect_q ? STRETCH_SECT : STRETCH_PARA) : 6'd0;
        end
        EMIT_WORD: begin
          element_q <= ELEM_SIL;
          unit_q    <= UNITS_WORD;
          stretch_q <= fe_q ? STRETCH_WORD : 6'd0;
        end
        EMIT_LETTER: begin
          element_q <= ELEM_SIL;
          unit_q    <= UNITS_LETTER;
          stretch_q <= fe_q ? STRETCH_LETTER : 6'd0;
        end
        EMIT_MARK: begin
          element_q <= sh_q[6] ? ELEM_DAH : ELEM_DIT;
          unit_q    <= 5'd0;
          stretch_q <= 6'd0;
        end
        default: begin
          element_q <= ELEM_SIL;
          unit_q    <= UNITS_ELEM;
          stretch_q <= 6'd0;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign element_o      = element_q;
  assign unit_gaps_o    = unit_q;
  assign stretch_gaps_o = stretch_q;
  assign unknown_char_o = unknown_q;
  assign last_o         = last_q;

`include "text_to_morse_element_encoder_core_assert.svh"

  `TMENC_ASSERT(a_no_overwrite, (out_valid_q && out_stall_i) |-> (cmd_i.emit == EMIT_NONE), "result overwritten while stalled")
  `TMENC_ASSERT(a_mark_avail, (cmd_i.emit == EMIT_MARK) |-> (rem_q != 3'd0), "mark emitted with none left")
  `TMENC_ASSERT(a_last_mark_drains, (cmd_i.emit == EMIT_MARK && cmd_i.last) |=> (rem_q == 3'd0), "marks left after last mark")
  `TMENC_ASSERT(a_mark_no_units, (out_valid_q && element_q != ELEM_SIL) |-> (unit_q == 5'd0 && stretch_q == 6'd0), "mark carries silence units")

endmodule

`default_nettype wire

// File: src/text_to_morse_element_encoder_core.sv
// Morse element encoder: one character per input transaction, then 0 to 15
// result transactions. A printable character stalls the input until its last
// result is issued (one result per cycle while the output is not stalled);
// CR, LF and white space give no result. Output stalls pause the sequencer.
// Reset clears spacing state and the Farnsworth enable; no clearing pass.
`default_nettype none

module text_to_morse_element_encoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [20:0] char_code_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  element_o,
  output logic [4:0]  unit_gaps_o,
  output logic [5:0]  stretch_gaps_o,
  output logic        unknown_char_o,
  output logic        last_o
);
  import tmenc_pkg::*;

  tmenc_cmd_t    cmd;
  tmenc_status_t st;

  assign cfg_ready_o = 1'b1;

  tmenc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  tmenc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .char_code_i    (char_code_i),
    .cmd_i          (cmd),
    .st_o           (st),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .element_o      (element_o),
    .unit_gaps_o    (unit_gaps_o),
    .stretch_gaps_o (stretch_gaps_o),
    .unknown_char_o (unknown_char_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire

// File: bench/text_to_morse_element_encoder_checker.sv
// Checker for the Morse element encoder: watches the config, character and element channels,
// predicts the element stream of each character and compares it with what the block sends.
// Depends on tmenc_pkg for the element codes and the CR/LF code points.
`default_nettype none

module text_to_morse_element_encoder_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic              cfg_data_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [20:0]       char_code_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [1:0]        element_i,
  input  logic [4:0]        unit_gaps_i,
  input  logic [5:0]        stretch_gaps_i,
  input  logic              unknown_char_i,
  input  logic              last_i,
  output int unsigned       errors_o,
  output int unsigned       pending_o
);
  import tmenc_pkg::*;

  localparam int unsigned ReportLimit = 10;

  localparam logic [4:0] GapParagraph = 5'd14;
  localparam logic [4:0] GapSection   = 5'd28;
  localparam logic [4:0] GapWord      = 5'd4;
  localparam logic [4:0] GapLetter    = 5'd3;
  localparam logic [4:0] GapMark      = 5'd1;
  localparam logic [5:0] FwParagraph  = 6'd21;
  localparam logic [5:0] FwSection    = 6'd42;
  localparam logic [5:0] FwWord       = 6'd4;
  localparam logic [5:0] FwLetter     = 6'd3;
  localparam logic [1:0] NlSaturated  = 2'd3;
  localparam logic [1:0] NlParagraph  = 2'd2;
  localparam logic [10:0] NoCode      = 11'h000;

  // {length[2:0], 1'b0, pattern[6:0]}, pattern sent MSB first
  localparam logic [10:0] LETTER_CODES [0:101] = '{
    11'h000, 11'h000, 11'h000, 11'h000, 11'h000, 11'h000, 11'h000, 11'h000,
    11'h000, 11'h000, 11'h000, 11'h000, 11'h000, 11'h000, 11'h000, 11'h000,
    11'h000, 11'h000, 11'h000, 11'h000, 11'h000, 11'h000, 11'h000, 11'h000,
    11'h000, 11'h000, 11'h000, 11'h000, 11'h000, 11'h000, 11'h000, 11'h000,
    11'h000,
    11'h62B, 11'h612, 11'h000, 11'h709, 11'h605, 11'h000, 11'h61E,
    11'h516, 11'h62D, 11'h515, 11'h50A, 11'h633, 11'h621, 11'h615, 11'h512,
    11'h51F, 11'h50F, 11'h507, 11'h503, 11'h501, 11'h500, 11'h510, 11'h518,
    11'h51C, 11'h51E,
    11'h638, 11'h62A, 11'h000, 11'h511, 11'h000, 11'h60C, 11'h61A,
    11'h201, 11'h408, 11'h40A, 11'h304, 11'h100, 11'h402, 11'h306, 11'h400,
    11'h200, 11'h407, 11'h305, 11'h404, 11'h203, 11'h202, 11'h307, 11'h406,
    11'h40D, 11'h302, 11'h300, 11'h101, 11'h301, 11'h401, 11'h303, 11'h409,
    11'h40B, 11'h40C,
    11'h000, 11'h000, 11'h000, 11'h000, 11'h60D,
    11'h405, 11'h40E, 11'h50D, 11'h514, 11'h403, 11'h504
  };

  typedef struct packed {
    logic [1:0] element;
    logic [4:0] units;
    logic [5:0] stretch;
    logic       unknown;
    logic       last;
  } morse_result_t;

  morse_result_t expected_elements[$];
  morse_result_t char_elements[$];
  logic          farnsworth_on = 1'b0;
  logic [1:0]    newlines = '0;
  logic          word_space = 1'b0;
  int unsigned   fail_count = 0;

  assign errors_o = fail_count;

  function automatic logic is_blank(input logic [20:0] c);
    return c == 21'd9 || c == 21'd11 || c == 21'd12 || c == 21'd32 ||
           c == 21'h1680 || c == 21'h2028 || c == 21'h2029 || c == 21'h205F ||
           c == 21'h3000 || (c >= 21'h2000 && c <= 21'h200A && c != 21'h2007);
  endfunction

  function automatic logic [10:0] code_entry(input logic [20:0] c);
    logic [20:0] u;
    logic [6:0]  slot;
    u = c;
    if ((c >= 21'h61 && c <= 21'h7A) || (c >= 21'hE0 && c <= 21'hFE && c != 21'hF7)) begin
      u = c - 21'h20;
    end else if (c == 21'h131) begin
      u = 21'h49;
    end else if (c == 21'h17F) begin
      u = 21'h53;
    end
    slot = u[6:0];
    if (u > 21'd95) begin
      case (u)
        21'hA0:                slot = 7'd32;
        21'hAB, 21'hBB:        slot = 7'd34;
        21'hC4, 21'hC6:        slot = 7'd96;
        21'hD3, 21'hD6, 21'hD8: slot = 7'd97;
        21'hC0, 21'hC5:        slot = 7'd98;
        21'hC7:                slot = 7'd99;
        21'hDC:                slot = 7'd100;
        21'hC9:                slot = 7'd101;
        21'hC1:                slot = 7'd65;
        21'hCF:                slot = 7'd73;
        21'hCB:                slot = 7'd69;
        21'h2019:              slot = 7'd39;
        default:               return NoCode;
      endcase
    end
    return LETTER_CODES[slot];
  endfunction

  task automatic add_element(input logic [1:0] e, input logic [4:0] u, input logic [5:0] s);
    morse_result_t r;
    r = '{element: e, units: u, stretch: s, unknown: 1'b0, last: 1'b0};
    char_elements.push_back(r);
  endtask

  task automatic encode_char(input logic [20:0] c);
    logic [10:0]   entry;
    int unsigned   len;
    morse_result_t r;
    if (c == CHAR_CR) return;
    if (c == CHAR_LF) begin
      if (newlines != NlSaturated) newlines = newlines + 2'd1;
      word_space = 1'b1;
      return;
    end
    if (is_blank(c)) begin
      word_space = 1'b1;
      return;
    end
    char_elements.delete();
    if (newlines == NlParagraph) begin
      add_element(ELEM_SIL, GapParagraph, farnsworth_on ? FwParagraph : 6'd0);
      word_space = 1'b0;
    end else if (newlines == NlSaturated) begin
      add_element(ELEM_SIL, GapSection, farnsworth_on ? FwSection : 6'd0);
      word_space = 1'b0;
    end
    newlines = '0;
    if (word_space) add_element(ELEM_SIL, GapWord, farnsworth_on ? FwWord : 6'd0);
    word_space = 1'b0;
    add_element(ELEM_SIL, GapLetter, farnsworth_on ? FwLetter : 6'd0);
    entry = code_entry(c);
    len = 32'(entry[10:8]);
    for (int i = 0; i < len; i++) begin
      if (i > 0) add_element(ELEM_SIL, GapMark, 6'd0);
      add_element(entry[len - 1 - i] ? ELEM_DAH : ELEM_DIT, 5'd0, 6'd0);
    end
    foreach (char_elements[k]) begin
      r = char_elements[k];
      r.unknown = (len == 0);
      r.last = (k == char_elements.size() - 1);
      expected_elements.push_back(r);
    end
  endtask

  task automatic report(input string what, input morse_result_t want, input morse_result_t got);
    fail_count++;
    if (fail_count <= ReportLimit) begin
      $display("%0t %s: expected elem=%0d units=%0d stretch=%0d unk=%0b last=%0b",
               $time, what, want.element, want.units, want.stretch, want.unknown, want.last);
      $display("%0t %s:      got elem=%0d units=%0d stretch=%0d unk=%0b last=%0b",
               $time, what, got.element, got.units, got.stretch, got.unknown, got.last);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    morse_result_t got;
    morse_result_t want;
    if (!rst_ni) begin
      farnsworth_on = 1'b0;
      newlines = '0;
      word_space = 1'b0;
      expected_elements.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = {element_i, unit_gaps_i, stretch_gaps_i, unknown_char_i, last_i};
        if (expected_elements.size() == 0) begin
          report("unexpected element", '0, got);
        end else begin
          want = expected_elements.pop_front();
          if (got !== want) report("element mismatch", want, got);
        end
      end
      if (cfg_valid_i && cfg_ready_i) farnsworth_on = cfg_data_i;
      if (in_valid_i && !in_stall_i) encode_char(char_code_i);
    end
    pending_o <= expected_elements.size();
  end

endmodule

`default_nettype wire

// File: bench/tb_text_to_morse_element_encoder_core.sv
// Testbench top for text_to_morse_element_encoder_core: drives characters, config writes
// and output stalls, and gives the verdict from text_to_morse_element_encoder_checker.
// Depends on tmenc_pkg and the block's RTL.
`default_nettype none

module tb_text_to_morse_element_encoder_core;
  import tmenc_pkg::*;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned TailCycles = 20;

  localparam logic [20:0] BLANKS [0:9] = '{
    21'd9, 21'd11, 21'd12, 21'd32, 21'h1680, 21'h2000, 21'h200A, 21'h2028, 21'h205F, 21'h3000
  };
  localparam logic [20:0] ACCENTED [0:19] = '{
    21'hC4, 21'hC6, 21'hD3, 21'hD6, 21'hD8, 21'hC0, 21'hC5, 21'hC7, 21'hDC, 21'hC9,
    21'hE9, 21'hFC, 21'h131, 21'h17F, 21'h2019, 21'hAB, 21'hBB, 21'hA0, 21'hF7, 21'h2007
  };
  localparam logic [20:0] DIRECTED [0:26] = '{
    21'h45, 21'h24, 21'd13, 21'h61, 21'd10, 21'd10, 21'h42,
    21'd10, 21'd10, 21'd10, 21'd10, 21'h63, 21'd32, 21'h44,
    21'h2007, 21'h1FFFFF, 21'h2019, 21'hC1, 21'hF6, 21'h131, 21'h17F,
    21'hF7, 21'h23, 21'h0, 21'h5F, 21'hA0, 21'hE0
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_data = 1'b0;
  logic        in_valid = 1'b0;
  logic [20:0] char_code = '0;
  logic        out_stall = 1'b0;
  logic        cfg_ready;
  logic        in_stall;
  logic        out_valid;
  logic [1:0]  element;
  logic [4:0]  unit_gaps;
  logic [5:0]  stretch_gaps;
  logic        unknown_char;
  logic        last;
  int unsigned failures;
  int unsigned pending;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  logic        calm = 1'b0;

  always #5 clk_i = ~clk_i;

  text_to_morse_element_encoder_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .char_code_i   (char_code),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .element_o     (element),
    .unit_gaps_o   (unit_gaps),
    .stretch_gaps_o(stretch_gaps),
    .unknown_char_o(unknown_char),
    .last_o        (last)
  );

  text_to_morse_element_encoder_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .char_code_i   (char_code),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .element_i     (element),
    .unit_gaps_i   (unit_gaps),
    .stretch_gaps_i(stretch_gaps),
    .unknown_char_i(unknown_char),
    .last_i        (last),
    .errors_o      (failures),
    .pending_o     (pending)
  );

  // receiver stalls in random bursts
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 13);
    end
    out_stall <= (stall_left != 0) && !calm;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_char(input logic [20:0] c);
    int unsigned gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    char_code <= c;
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_farnsworth(input logic on);
    drain();
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data <= on;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [20:0] pick_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      return 21'(32'h41 + $urandom_range(0, 25) + ($urandom_range(0, 1) ? 32'h20 : 32'h0));
    end
    if (r < 60) return 21'($urandom_range(32'h21, 32'h5F));
    if (r < 70) return BLANKS[$urandom_range(0, 9)];
    if (r < 78) return CHAR_LF;
    if (r < 81) return CHAR_CR;
    if (r < 88) return ACCENTED[$urandom_range(0, 19)];
    return 21'($urandom() & 32'h1FFFFF);
  endfunction

  task automatic send_text(input int unsigned count);
    int unsigned sent;
    int unsigned reps;
    logic [20:0] c;
    sent = 0;
    while (sent < count) begin
      c = pick_char();
      reps = (c == CHAR_LF) ? $urandom_range(1, 4) : 1;
      repeat (reps) push_char(c);
      if (c != CHAR_CR) sent++;
    end
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    write_farnsworth(1'b1);
    foreach (DIRECTED[i]) push_char(DIRECTED[i]);
    write_farnsworth(1'b0);
    send_text(20);
    drain();
    send_text(20);
    write_farnsworth(1'b1);
    send_text(25);
    calm = 1'b1;
    send_text(15);
    @(negedge clk_i);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (TailCycles) @(posedge clk_i);
    if (failures == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
